### rtl/core/sorted_top_k_score_list_assert.svh
// assertion macros used by the checker file
`ifndef SORTED_TOP_K_SCORE_LIST_ASSERT_SVH
`define SORTED_TOP_K_SCORE_LIST_ASSERT_SVH

// same-cycle implication on the rising clock edge, masked during reset
`define STKL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted list check failed");

// next-cycle implication on the rising clock edge, masked during reset
`define STKL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted list check failed");

`endif

### rtl/core/stkl_pkg.sv
// ----------------------------------------------------------------------------
// stkl_pkg
// Types and constants shared by the sorted top-k score list and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package stkl_pkg;

  // list geometry
  localparam int unsigned Depth  = 5;
  localparam int unsigned IdxW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned ScoreW = 16;
  localparam int unsigned TagW   = 16;
  localparam int unsigned RankW  = 3;
  localparam int unsigned StatW  = 3;

  // input operations
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  // result status codes
  typedef enum logic [StatW-1:0] {
    STS_INSERTED   = 3'd0,
    STS_NOT_PLACED = 3'd1,
    STS_DELETED    = 3'd2,
    STS_NOT_FOUND  = 3'd3,
    STS_ENTRY      = 3'd4
  } status_e;

  // one list entry
  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic [TagW-1:0]   tag;
  } entry_t;

  // control broadcast to every cell
  typedef struct packed {
    logic sel_ins;  // compare mode: greater-than for insert, less-or-equal otherwise
    logic wr_ins;   // commit an insert
    logic wr_del;   // commit a delete
    logic rot;      // rotate the list up by one rank
  } cell_ctrl_t;

  // compare results reported by a cell
  typedef struct packed {
    logic flag;  // cell is at or below the touched position
    logic head;  // cell is the touched position
    logic eq;    // stored score equals the broadcast score
    logic gt;    // broadcast score is above the stored score
  } cell_stat_t;

endpackage

`default_nettype wire

### rtl/core/stkl_cell.sv
// ----------------------------------------------------------------------------
// stkl_cell
// One rank of the sorted list: holds a score and tag, compares against the
// broadcast score and takes its next entry from a neighbor or the broadcast.
// ----------------------------------------------------------------------------
`default_nettype none

module stkl_cell
  import stkl_pkg::*;
(
  input  wire  logic              clk_i,
  input  wire  logic              rst_ni,
  input  wire  cell_ctrl_t        ctrl_i,
  input  wire  logic [ScoreW-1:0] bc_score_i,
  input  wire  logic [TagW-1:0]   bc_tag_i,
  input  wire  logic              up_flag_i,
  input  wire  entry_t            up_ent_i,
  input  wire  entry_t            dn_ent_i,
  output entry_t                  ent_o,
  output cell_stat_t              stat_o
);

  entry_t ent_q, ent_d;
  logic   gt, le, flag;

  // compare against the broadcast score
  assign gt   = bc_score_i > ent_q.score;
  assign le   = ent_q.score <= bc_score_i;
  assign flag = ctrl_i.sel_ins ? gt : le;

  assign stat_o.flag = flag;
  assign stat_o.head = flag & ~up_flag_i;
  assign stat_o.eq   = ent_q.score == bc_score_i;
  assign stat_o.gt   = gt;
  assign ent_o       = ent_q;

  // next entry: new word at the head, shift down below it, shift up on delete or rotate
  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.wr_ins && gt) begin
      if (~up_flag_i) begin
        ent_d.score = bc_score_i;
        ent_d.tag   = bc_tag_i;
      end else begin
        ent_d = up_ent_i;
      end
    end else if ((ctrl_i.wr_del && le) || ctrl_i.rot) begin
      ent_d = dn_ent_i;
    end
  end

  // entry storage, reset to score 0 and anonymous tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/sorted_top_k_score_list.sv
// Sorted top-k score list: a chain of Depth cells keeps (score, tag) pairs in
// descending order, rank 0 highest, all zero after reset. Insert and delete
// words are taken one per cycle unless the result register is stalled: every
// cell compares with the broadcast score in parallel and the whole chain
// shifts in the same edge, giving one result word with last set. A read word
// gives Depth result words, one per cycle while the output side does not
// stall, by rotating the chain up through rank 0 into the output register;
// the input is not ready while the read is in progress. Opcode 3 is taken and
// gives no result. Ranks are reported modulo 8.
// ----------------------------------------------------------------------------
// sorted_top_k_score_list
// Top level: cell chain, operation control and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_top_k_score_list
  import stkl_pkg::*;
(
  input  wire  logic              clk_i,
  input  wire  logic              rst_ni,
  input  wire  logic              in_valid_i,
  output logic                    in_ready_o,
  input  wire  logic [1:0]        opcode_i,
  input  wire  logic [ScoreW-1:0] score_i,
  input  wire  logic [TagW-1:0]   player_tag_i,
  output logic                    out_valid_o,
  input  wire  logic              out_ready_i,
  output logic [StatW-1:0]        status_o,
  output logic [RankW-1:0]        rank_o,
  output logic [ScoreW-1:0]       entry_score_o,
  output logic [TagW-1:0]         entry_tag_o,
  output logic                    last_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [IdxW-1:0]   cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [StatW-1:0]  status_q, status_d;
  logic [RankW-1:0]  rank_q, rank_d;
  logic [ScoreW-1:0] score_q, score_d;
  logic [TagW-1:0]   tag_q, tag_d;
  logic              last_q, last_d;

  cell_ctrl_t        ctrl;
  entry_t            ent [Depth];
  cell_stat_t        stat [Depth];
  logic [Depth-1:0]  flag_v, head_v, eq_v;
  logic              out_free, acc, rd_step, is_ins, is_del;
  logic              placed, found, rd_last;
  logic [IdxW-1:0]   head_idx;
  logic [RankW+IdxW-1:0] head_ext, cnt_ext;

  // handshake
  assign out_free   = ~out_valid_q | out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) & out_free;
  assign acc        = in_valid_i & in_ready_o;
  assign rd_step    = (state_q == S_READ) & out_free;
  assign is_ins     = opcode_i == OP_INSERT;
  assign is_del     = opcode_i == OP_DELETE;
  assign rd_last    = cnt_q == IdxW'(Depth - 1);

  // cell control
  assign placed       = stat[Depth-1].gt;
  assign found        = |eq_v;
  assign ctrl.sel_ins = is_ins;
  assign ctrl.wr_ins  = acc & is_ins & placed;
  assign ctrl.wr_del  = acc & is_del & found;
  assign ctrl.rot     = rd_step;

  // cell chain
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    entry_t up_ent, dn_ent;
    logic   up_flag;

    if (i == 0) begin : g_top
      assign up_ent  = '0;
      assign up_flag = 1'b0;
    end else begin : g_mid
      assign up_ent  = ent[i-1];
      assign up_flag = flag_v[i-1];
    end

    if (i == Depth - 1) begin : g_bot
      assign dn_ent = ctrl.rot ? ent[0] : '0;
    end else begin : g_up
      assign dn_ent = ent[i+1];
    end

    stkl_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .bc_score_i (score_i),
      .bc_tag_i   (player_tag_i),
      .up_flag_i  (up_flag),
      .up_ent_i   (up_ent),
      .dn_ent_i   (dn_ent),
      .ent_o      (ent[i]),
      .stat_o     (stat[i])
    );

    assign flag_v[i] = stat[i].flag;
    assign head_v[i] = stat[i].head;
    assign eq_v[i]   = stat[i].eq;
  end

  // one-hot head position to index
  always_comb begin
    head_idx = '0;
    for (int i = 0; i < Depth; i++) begin
      if (head_v[i]) begin
        head_idx = head_idx | IdxW'(i);
      end
    end
  end

  // ranks are reported modulo the rank field
  assign head_ext = {{RankW{1'b0}}, head_idx};
  assign cnt_ext  = {{RankW{1'b0}}, cnt_q};

  // read sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc && opcode_i == OP_READ) begin
          state_d = S_READ;
          cnt_d   = '0;
        end
      end
      S_READ: begin
        if (rd_step) begin
          cnt_d = IdxW'(cnt_q + 1'b1);
          if (rd_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result word
  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    status_d    = status_q;
    rank_d      = rank_q;
    score_d     = score_q;
    tag_d       = tag_q;
    last_d      = last_q;
    if (acc && (is_ins || is_del)) begin
      out_valid_d = 1'b1;
      score_d     = score_i;
      tag_d       = player_tag_i;
      last_d      = 1'b1;
      if (is_ins) begin
        status_d = placed ? STS_INSERTED : STS_NOT_PLACED;
        rank_d   = placed ? head_ext[RankW-1:0] : '0;
      end else begin
        status_d = found ? STS_DELETED : STS_NOT_FOUND;
        rank_d   = found ? head_ext[RankW-1:0] : '0;
      end
    end else if (rd_step) begin
      out_valid_d = 1'b1;
      status_d    = STS_ENTRY;
      rank_d      = cnt_ext[RankW-1:0];
      score_d     = ent[0].score;
      tag_d       = ent[0].tag;
      last_d      = rd_last;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    rank_q   <= rank_d;
    score_q  <= score_d;
    tag_q    <= tag_d;
    last_q   <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign rank_o        = rank_q;
  assign entry_score_o = score_q;
  assign entry_tag_o   = tag_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

### rtl/core/stkl_checker.sv
// ----------------------------------------------------------------------------
// stkl_checker
// Port-level checks of the sorted top-k score list, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_top_k_score_list_assert.svh"

module stkl_checker
  import stkl_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic [1:0]        opcode_i,
  input wire logic [ScoreW-1:0] score_i,
  input wire logic [TagW-1:0]   player_tag_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [StatW-1:0]  status_o,
  input wire logic [RankW-1:0]  rank_o,
  input wire logic [ScoreW-1:0] entry_score_o,
  input wire logic [TagW-1:0]   entry_tag_o,
  input wire logic              last_o
);

  // a stalled result word holds
  `STKL_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(status_o) && $stable(rank_o) && $stable(entry_score_o) &&
    $stable(entry_tag_o) && $stable(last_o))

  // insert and delete answers are single words
  `STKL_ASSERT_IMP(a_single_last, out_valid_o && status_o != STS_ENTRY, last_o)

  // misses report rank zero
  `STKL_ASSERT_IMP(a_miss_rank,
    out_valid_o && (status_o == STS_NOT_PLACED || status_o == STS_NOT_FOUND),
    rank_o == '0)

  // no new word is taken while a list dump is in flight
  `STKL_ASSERT_IMP(a_read_stall, out_valid_o && status_o == STS_ENTRY && !last_o,
    !in_ready_o)

endmodule

bind sorted_top_k_score_list stkl_checker u_stkl_checker (.*);

`default_nettype wire
